[rtl/avcl_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// avcl_pkg
// Constants, codes and helpers for the axis velocity command limiter.
// ---------------------------------------------------------------------------
package avcl_pkg;

  localparam int unsigned REG_COUNT   = 8;
  localparam int unsigned PADDR_WIDTH = 5;

  typedef enum logic [2:0] {
    REG_MIN_VELOCITY = 3'd0,
    REG_MAX_VELOCITY = 3'd1,
    REG_MIN_POSITION = 3'd2,
    REG_MAX_POSITION = 3'd3,
    REG_HOME_X       = 3'd4,
    REG_HOME_Y       = 3'd5,
    REG_HOME_Z       = 3'd6,
    REG_GOAL_X       = 3'd7
  } reg_index_t;

  // item kind carried on cmd
  localparam logic CMD_ACCEL = 1'b0;
  localparam logic CMD_STATE = 1'b1;

  // register reset values, Q16.16
  localparam logic signed [31:0] HOME_X_RST = -32'sd22872;
  localparam logic signed [31:0] HOME_Y_RST = 32'sd16384;
  localparam logic signed [31:0] HOME_Z_RST = 32'sd11403;
  localparam logic signed [31:0] GOAL_X_RST = -32'sd17760;

  // 0.008 and 0.01 as fractions of 2^32
  localparam logic signed [26:0] GAIN_008 = 27'sd34359738;
  localparam logic signed [26:0] GAIN_001 = 27'sd42949673;

  localparam logic [31:0] HOLD_MS    = 32'd3000;
  localparam logic [5:0]  STEP_LIMIT = 6'd50;
  localparam logic [5:0]  STEP_MAX   = 6'd63;

  // exclusive bounds: |x - goal| < 0.01 -> |d| <= 655, |v| < 0.02 -> |v| <= 1310
  localparam logic signed [32:0] GOAL_LIM  = 33'sd656;
  localparam logic signed [32:0] SPEED_LIM = 33'sd1311;
  // each home offset below 256 LSB, then sum of squares below 0.002^2
  localparam logic signed [33:0] HOME_AXIS_LIM = 34'sd256;
  localparam logic [17:0]        HOME_SQ_LIM   = 18'd17180;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/axis_velocity_command_limiter.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// axis_velocity_command_limiter
// Integrates x acceleration into a clamped velocity command with workspace
// lookahead stop, goal detection, timed hold and proportional return home.
// ---------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  cmd accel_x pos_x pos_y pos_z meas_vel_x now_ms
//  out      out_valid/out_stall  vel_x vel_y vel_z returning goal_hit
//  cfg      APB psel/penable     paddr[4:2] selects one of 8 registers
//
//  One item per cycle unless a state item meets a stalled output: an input
//  register feeds the update logic, which writes the state and the output
//  register in the same edge, loading a result for each state item.
//  The path is set by the clamp, the 0.01 lookahead multiply and its compare.
//  Acceleration items give no result; the 0.008 product is taken there.
//  Reset is synchronous; state, config registers and valid flags return to defaults.
//  A stalled output holds the input register; in_stall rises when it is full and cannot drain.
// ---------------------------------------------------------------------------
module axis_velocity_command_limiter
  import avcl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      cmd,
  input  logic signed [31:0]        accel_x,
  input  logic signed [31:0]        pos_x,
  input  logic signed [31:0]        pos_y,
  input  logic signed [31:0]        pos_z,
  input  logic signed [31:0]        meas_vel_x,
  input  logic [31:0]               now_ms,
  // output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        vel_x,
  output logic signed [31:0]        vel_y,
  output logic signed [31:0]        vel_z,
  output logic                      returning,
  output logic                      goal_hit,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_WIDTH-1:0]    paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  // configuration registers
  logic signed [31:0] min_velocity, max_velocity, min_position, max_position;
  logic signed [31:0] home_x, home_y, home_z, goal_x;

  // input register
  logic               item_valid;
  logic               item_cmd;
  logic signed [31:0] item_accel_x, item_pos_x, item_pos_y, item_pos_z;
  logic signed [31:0] item_meas_vel_x;
  logic [31:0]        item_now_ms;

  // block state
  logic signed [31:0] cmd_vel_x, cmd_vel_y, cmd_vel_z, held_accel;
  logic signed [27:0] held_inc;
  logic               armed, return_mode, stop_latched;
  logic [5:0]         step_count;
  logic [31:0]        hold_start_ms;

  logic signed [31:0] cmd_vel_x_next, cmd_vel_y_next, cmd_vel_z_next, held_accel_next;
  logic signed [27:0] held_inc_next;
  logic               armed_next, return_mode_next, stop_latched_next, goal_hit_next;
  logic [5:0]         step_count_next;
  logic [31:0]        hold_start_ms_next;

  logic fire, out_free, cfg_write;
  reg_index_t cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[PADDR_WIDTH-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_velocity <= '0;
      max_velocity <= '0;
      min_position <= '0;
      max_position <= '0;
      home_x       <= HOME_X_RST;
      home_y       <= HOME_Y_RST;
      home_z       <= HOME_Z_RST;
      goal_x       <= GOAL_X_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_VELOCITY: min_velocity <= pwdata;
        REG_MAX_VELOCITY: max_velocity <= pwdata;
        REG_MIN_POSITION: min_position <= pwdata;
        REG_MAX_POSITION: max_position <= pwdata;
        REG_HOME_X:       home_x       <= pwdata;
        REG_HOME_Y:       home_y       <= pwdata;
        REG_HOME_Z:       home_z       <= pwdata;
        REG_GOAL_X:       goal_x       <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_MIN_VELOCITY: prdata = min_velocity;
      REG_MAX_VELOCITY: prdata = max_velocity;
      REG_MIN_POSITION: prdata = min_position;
      REG_MAX_POSITION: prdata = max_position;
      REG_HOME_X:       prdata = home_x;
      REG_HOME_Y:       prdata = home_y;
      REG_HOME_Z:       prdata = home_z;
      REG_GOAL_X:       prdata = goal_x;
    endcase
  end

  // handshake: acceleration items never wait for the output side
  assign out_free = !out_valid || !out_stall;
  assign fire     = item_valid && (item_cmd == CMD_ACCEL || out_free);
  assign in_stall = item_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || fire) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_cmd        <= cmd;
      item_accel_x    <= accel_x;
      item_pos_x      <= pos_x;
      item_pos_y      <= pos_y;
      item_pos_z      <= pos_z;
      item_meas_vel_x <= meas_vel_x;
      item_now_ms     <= now_ms;
    end
  end

  // ---- datapath ----
  // rounded 0.008 * accel, taken once per acceleration transaction
  logic signed [59:0] inc_prod, inc_rnd;
  assign inc_prod = 60'(item_accel_x) * 60'(GAIN_008);
  assign inc_rnd  = inc_prod + (60'sd1 <<< 31);

  // integrate and clamp
  logic signed [33:0] vel_sum;
  logic signed [31:0] vel_clamp;
  assign vel_sum = 34'(cmd_vel_x) + 34'(held_inc);
  always_comb begin
    if (vel_sum < 34'(min_velocity)) begin
      vel_clamp = min_velocity;
    end else if (vel_sum > 34'(max_velocity)) begin
      vel_clamp = max_velocity;
    end else begin
      vel_clamp = vel_sum[31:0];
    end
  end

  // lookahead position after 0.01 s
  logic signed [59:0] look_prod, look_rnd;
  logic signed [33:0] ahead;
  logic               out_of_range;
  assign look_prod    = 60'(vel_clamp) * 60'(GAIN_001);
  assign look_rnd     = look_prod + (60'sd1 <<< 31);
  assign ahead        = 34'(item_pos_x) + 34'($signed(look_rnd[59:32]));
  assign out_of_range = (ahead > 34'(max_position)) || (ahead < 34'(min_position));

  logic below_mid;
  assign below_mid = (34'(item_pos_x) <<< 1) < (34'(min_position) + 34'(max_position));

  logic [5:0] step_inc;
  assign step_inc = (step_count < STEP_MAX) ? step_count + 6'd1 : step_count;

  // goal window
  logic signed [32:0] goal_diff;
  logic               goal_in;
  assign goal_diff = 33'(item_pos_x) - 33'(goal_x);
  assign goal_in   = goal_diff < GOAL_LIM && goal_diff > -GOAL_LIM &&
                     33'(item_meas_vel_x) < SPEED_LIM &&
                     33'(item_meas_vel_x) > -SPEED_LIM;

  // return home: half the offset, rounded up on ties
  logic signed [33:0] dx, dy, dz;
  logic signed [31:0] home_vel_x, home_vel_y, home_vel_z;
  assign dx = 34'(home_x) - 34'(item_pos_x);
  assign dy = 34'(home_y) - 34'(item_pos_y);
  assign dz = 34'(home_z) - 34'(item_pos_z);
  assign home_vel_x = sat32((dx + 34'sd1) >>> 1);
  assign home_vel_y = sat32((dy + 34'sd1) >>> 1);
  assign home_vel_z = sat32((dz + 34'sd1) >>> 1);

  // squares only matter once every offset is inside +/-255
  logic               axes_close, near_home;
  logic signed [8:0]  dx_lo, dy_lo, dz_lo;
  logic signed [17:0] sq_x, sq_y, sq_z;
  logic [17:0]        sq_sum;
  assign axes_close = dx < HOME_AXIS_LIM && dx > -HOME_AXIS_LIM &&
                      dy < HOME_AXIS_LIM && dy > -HOME_AXIS_LIM &&
                      dz < HOME_AXIS_LIM && dz > -HOME_AXIS_LIM;
  assign dx_lo  = dx[8:0];
  assign dy_lo  = dy[8:0];
  assign dz_lo  = dz[8:0];
  assign sq_x   = dx_lo * dx_lo;
  assign sq_y   = dy_lo * dy_lo;
  assign sq_z   = dz_lo * dz_lo;
  assign sq_sum = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
  assign near_home = axes_close && (sq_sum < HOME_SQ_LIM);

  logic [31:0] hold_elapsed;
  assign hold_elapsed = item_now_ms - hold_start_ms;

  // ---- state update ----
  always_comb begin
    cmd_vel_x_next     = cmd_vel_x;
    cmd_vel_y_next     = cmd_vel_y;
    cmd_vel_z_next     = cmd_vel_z;
    held_accel_next    = held_accel;
    held_inc_next      = held_inc;
    armed_next         = armed;
    return_mode_next   = return_mode;
    stop_latched_next  = stop_latched;
    step_count_next    = step_count;
    hold_start_ms_next = hold_start_ms;
    goal_hit_next      = 1'b0;
    if (fire) begin
      if (item_cmd == CMD_ACCEL) begin
        held_accel_next = item_accel_x;
        held_inc_next   = inc_rnd[59:32];
        armed_next      = 1'b1;
      end else if (return_mode) begin
        if (hold_elapsed > HOLD_MS) begin
          if (near_home) begin
            cmd_vel_x_next   = '0;
            cmd_vel_y_next   = '0;
            cmd_vel_z_next   = '0;
            return_mode_next = 1'b0;
            armed_next       = 1'b0;
          end else begin
            cmd_vel_x_next = home_vel_x;
            cmd_vel_y_next = home_vel_y;
            cmd_vel_z_next = home_vel_z;
          end
        end else begin
          cmd_vel_x_next = '0;
          cmd_vel_y_next = '0;
          cmd_vel_z_next = '0;
        end
      end else begin
        if (armed) begin
          step_count_next = step_inc;
          cmd_vel_x_next  = vel_clamp;
          if (stop_latched) begin
            // release only when pushing away from the nearer limit
            if (below_mid) begin
              if (held_accel <= 32'sd0) begin
                cmd_vel_x_next = '0;
              end else begin
                stop_latched_next = 1'b0;
              end
            end else begin
              if (held_accel >= 32'sd0) begin
                cmd_vel_x_next = '0;
              end else begin
                stop_latched_next = 1'b0;
              end
            end
            step_count_next = '0;
          end else if (step_inc > STEP_LIMIT && out_of_range) begin
            cmd_vel_x_next    = '0;
            stop_latched_next = 1'b1;
          end
        end
        cmd_vel_z_next = '0;
        if (goal_in) begin
          goal_hit_next      = 1'b1;
          return_mode_next   = 1'b1;
          hold_start_ms_next = item_now_ms;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_vel_x     <= '0;
      cmd_vel_y     <= '0;
      cmd_vel_z     <= '0;
      held_accel    <= '0;
      held_inc      <= '0;
      armed         <= 1'b0;
      return_mode   <= 1'b0;
      stop_latched  <= 1'b0;
      step_count    <= '0;
      hold_start_ms <= '0;
    end else begin
      cmd_vel_x     <= cmd_vel_x_next;
      cmd_vel_y     <= cmd_vel_y_next;
      cmd_vel_z     <= cmd_vel_z_next;
      held_accel    <= held_accel_next;
      held_inc      <= held_inc_next;
      armed         <= armed_next;
      return_mode   <= return_mode_next;
      stop_latched  <= stop_latched_next;
      step_count    <= step_count_next;
      hold_start_ms <= hold_start_ms_next;
    end
  end

  // ---- output register ----
  logic result_load;
  assign result_load = fire && (item_cmd == CMD_STATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      vel_x     <= cmd_vel_x_next;
      vel_y     <= cmd_vel_y_next;
      vel_z     <= cmd_vel_z_next;
      returning <= return_mode_next;
      goal_hit  <= goal_hit_next;
    end
  end

endmodule
